/* rtl/ipsp_pkg.sv */
// shared types and constants of the ips patch stream parser
package ipsp_pkg;

    localparam logic [3:0] EV_MAGIC_OK  = 4'd0;
    localparam logic [3:0] EV_REGULAR   = 4'd1;
    localparam logic [3:0] EV_WRITE     = 4'd2;
    localparam logic [3:0] EV_RLE       = 4'd3;
    localparam logic [3:0] EV_EOF       = 4'd4;
    localparam logic [3:0] EV_TRUNCATE  = 4'd5;
    localparam logic [3:0] EV_DONE      = 4'd6;
    localparam logic [3:0] EV_BAD_MAGIC = 4'd7;
    localparam logic [3:0] EV_EARLY_END = 4'd8;
    localparam logic [3:0] EV_TRAILING  = 4'd9;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [3:0]  event_res;
        logic [23:0] offset;
        logic [15:0] index;
        logic [7:0]  data_byte;
        logic [23:0] run_length;
        logic [31:0] hunk_position;
    } token_t;

endpackage

/* rtl/ipsp_if.sv */
// stream channel interfaces for input bytes and result events
interface ipsp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] byte_value;

    modport source (output valid, output command, output byte_value, input ready);
    modport sink (input valid, input command, input byte_value, output ready);
endinterface

interface ipsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [24:0] target_address;
    logic [7:0]  data_byte;
    logic [23:0] run_length;
    logic        zero_length;
    logic [31:0] hunk_position;

    modport source (output valid, output event_res, output target_address,
                    output data_byte, output run_length, output zero_length,
                    output hunk_position, input ready);
    modport sink (input valid, input event_res, input target_address,
                  input data_byte, input run_length, input zero_length,
                  input hunk_position, output ready);
endinterface

/* rtl/ips_patch_stream_parser_core.sv */
// top level of the ips patch stream parser
// Takes one patch beat per clock (a byte, or the end-of-stream command) and
// gives at most one event beat for each. The parser front handles each beat
// as it is accepted and is ready whenever the four-entry token queue has room,
// so a continuous stream runs at one beat per cycle while the sink keeps up.
// An event passes from the token queue into the output register, where the write
// address is summed. respect_trunc is taken when the eof marker completes.
// It must be written only while idle; the block itself does not enforce this.
module ips_patch_stream_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    ipsp_in_if.sink     in_ch,
    ipsp_out_if.source  out_ch
);

    logic              push;
    logic              push_ready;
    logic              pop;
    logic              head_valid;
    ipsp_pkg::token_t  push_token;
    ipsp_pkg::token_t  head_token;

    ipsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .q_ready    (push_ready),
        .push       (push),
        .push_token (push_token)
    );

    ipsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    ipsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_token (head_token),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

/* rtl/ipsp_front.sv */
// front part: accepts beats, runs the patch parser and pushes event tokens
module ipsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    ipsp_in_if.sink           in_ch,
    input  logic              q_ready,
    output logic              push,
    output ipsp_pkg::token_t  push_token
);

    localparam logic [3:0] PH_MAGIC      = 4'd0;
    localparam logic [3:0] PH_OFFSET     = 4'd1;
    localparam logic [3:0] PH_LENGTH     = 4'd2;
    localparam logic [3:0] PH_RLE_LENGTH = 4'd3;
    localparam logic [3:0] PH_RLE_FILL   = 4'd4;
    localparam logic [3:0] PH_PAYLOAD    = 4'd5;
    localparam logic [3:0] PH_AFTER_EOF  = 4'd6;
    localparam logic [3:0] PH_TRUNC      = 4'd7;
    localparam logic [3:0] PH_TAIL       = 4'd8;
    localparam logic [3:0] PH_FINISHED   = 4'd9;
    localparam logic [3:0] PH_FAILED     = 4'd10;

    localparam logic [23:0] EOF_WORD = 24'h454F46;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h50;
            3'd1:    r = 8'h41;
            3'd2:    r = 8'h54;
            3'd3:    r = 8'h43;
            3'd4:    r = 8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    logic        respect_trunc_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [23:0] shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] index_reg, index_next;
    logic [31:0] spos_reg, spos_next;
    logic [31:0] rpos_reg, rpos_next;

    logic        accept;
    logic        busy;
    logic [23:0] take_shift;
    logic [2:0]  take_count;
    logic [15:0] index_inc;

    assign in_ch.ready = q_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign busy        = (phase_reg != PH_FINISHED) && (phase_reg != PH_FAILED);
    assign take_shift  = {shift_reg[15:0], in_ch.byte_value};
    assign take_count  = count_reg + 3'd1;
    assign index_inc   = index_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        index_next  = index_reg;
        spos_next   = spos_reg;
        rpos_next   = rpos_reg;
        push        = 1'b0;
        push_token  = '0;
        if (accept && busy)
        begin
            if (in_ch.command)
            begin
                shift_next = '0;
                count_next = '0;
                push       = 1'b1;
                if ((phase_reg == PH_AFTER_EOF) || (phase_reg == PH_TAIL) ||
                    ((phase_reg == PH_TRUNC) && (count_reg == 3'd0)))
                begin
                    phase_next           = PH_FINISHED;
                    push_token.event_res = ipsp_pkg::EV_DONE;
                end
                else
                begin
                    phase_next           = PH_FAILED;
                    push_token.event_res = ipsp_pkg::EV_EARLY_END;
                end
            end
            else
            begin
                if (spos_reg != 32'hFFFF_FFFF)
                begin
                    spos_next = spos_reg + 32'd1;
                end
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (in_ch.byte_value != magic_byte(count_reg))
                        begin
                            shift_next = 24'd1;
                        end
                        count_next = take_count;
                        if (take_count >= 3'd5)
                        begin
                            push       = 1'b1;
                            count_next = '0;
                            shift_next = '0;
                            if ((shift_reg != 24'd0) ||
                                (in_ch.byte_value != magic_byte(count_reg)))
                            begin
                                phase_next           = PH_FAILED;
                                push_token.event_res = ipsp_pkg::EV_BAD_MAGIC;
                            end
                            else
                            begin
                                phase_next           = PH_OFFSET;
                                push_token.event_res = ipsp_pkg::EV_MAGIC_OK;
                            end
                        end
                    end
                    PH_OFFSET:
                    begin
                        if (count_reg == 3'd0)
                        begin
                            rpos_next = spos_reg;
                        end
                        shift_next = take_shift;
                        count_next = take_count;
                        if (take_count >= 3'd3)
                        begin
                            shift_next = '0;
                            count_next = '0;
                            if (take_shift == EOF_WORD)
                            begin
                                phase_next = respect_trunc_reg ? PH_TRUNC : PH_AFTER_EOF;
                                push       = 1'b1;
                                push_token.event_res     = ipsp_pkg::EV_EOF;
                                push_token.hunk_position = rpos_reg;
                            end
                            else
                            begin
                                offset_next = take_shift;
                                phase_next  = PH_LENGTH;
                            end
                        end
                    end
                    PH_LENGTH:
                    begin
                        shift_next = take_shift;
                        count_next = take_count;
                        if (take_count >= 3'd2)
                        begin
                            shift_next  = '0;
                            count_next  = '0;
                            length_next = take_shift[15:0];
                            if (take_shift[15:0] != 16'd0)
                            begin
                                index_next = '0;
                                phase_next = PH_PAYLOAD;
                                push       = 1'b1;
                                push_token.event_res     = ipsp_pkg::EV_REGULAR;
                                push_token.offset        = offset_reg;
                                push_token.run_length    = {8'd0, take_shift[15:0]};
                                push_token.hunk_position = rpos_reg;
                            end
                            else
                            begin
                                phase_next = PH_RLE_LENGTH;
                            end
                        end
                    end
                    PH_RLE_LENGTH:
                    begin
                        shift_next = take_shift;
                        count_next = take_count;
                        if (take_count >= 3'd2)
                        begin
                            shift_next  = '0;
                            count_next  = '0;
                            length_next = take_shift[15:0];
                            phase_next  = PH_RLE_FILL;
                        end
                    end
                    PH_RLE_FILL:
                    begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = PH_OFFSET;
                        push       = 1'b1;
                        push_token.event_res     = ipsp_pkg::EV_RLE;
                        push_token.offset        = offset_reg;
                        push_token.data_byte     = in_ch.byte_value;
                        push_token.run_length    = {8'd0, length_reg};
                        push_token.hunk_position = rpos_reg;
                    end
                    PH_PAYLOAD:
                    begin
                        index_next = index_inc;
                        if (index_inc >= length_reg)
                        begin
                            phase_next = PH_OFFSET;
                            shift_next = '0;
                            count_next = '0;
                        end
                        push = 1'b1;
                        push_token.event_res  = ipsp_pkg::EV_WRITE;
                        push_token.offset     = offset_reg;
                        push_token.index      = index_reg;
                        push_token.data_byte  = in_ch.byte_value;
                        push_token.run_length = {8'd0, length_reg};
                    end
                    PH_TRUNC:
                    begin
                        shift_next = take_shift;
                        count_next = take_count;
                        if (take_count >= 3'd3)
                        begin
                            shift_next = '0;
                            count_next = '0;
                            phase_next = PH_TAIL;
                            push       = 1'b1;
                            push_token.event_res  = ipsp_pkg::EV_TRUNCATE;
                            push_token.run_length = take_shift;
                        end
                    end
                    PH_TAIL:
                    begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = PH_AFTER_EOF;
                        push       = 1'b1;
                        push_token.event_res = ipsp_pkg::EV_TRAILING;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            respect_trunc_reg <= 1'b0;
            phase_reg         <= PH_MAGIC;
            shift_reg         <= '0;
            count_reg         <= '0;
            offset_reg        <= '0;
            length_reg        <= '0;
            index_reg         <= '0;
            spos_reg          <= '0;
            rpos_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                respect_trunc_reg <= cfg_wdata;
            end
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            spos_reg   <= spos_next;
            rpos_reg   <= rpos_next;
        end
    end

`ifndef SYNTHESIS
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED |=> phase_reg == PH_FAILED)
        else $error("failed phase left before reset");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept && busy)
        else $error("token pushed without an accepted beat");

    a_magic_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MAGIC |-> count_reg < 3'd5)
        else $error("magic byte count out of range");
`endif

endmodule

/* rtl/ipsp_queue.sv */
// short token queue between the parser front and the output back
module ipsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipsp_pkg::token_t  push_token,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output ipsp_pkg::token_t  head_token
);

    ipsp_pkg::token_t             mem_reg [ipsp_pkg::QDEPTH];
    logic [ipsp_pkg::QAW-1:0]     wptr_reg, rptr_reg;
    logic [ipsp_pkg::QCW-1:0]     count_reg;
    logic                         do_push, do_pop;

    assign push_ready = count_reg < ipsp_pkg::QCW'(ipsp_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_token = mem_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_token;
        end
    end

endmodule

/* rtl/ipsp_back.sv */
// back part: forms result fields from tokens and holds the output register
module ipsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ipsp_pkg::token_t  head_token,
    output logic              pop,
    ipsp_out_if.source        out_ch
);

    logic        valid_reg;
    logic [3:0]  event_reg;
    logic [24:0] addr_reg;
    logic [7:0]  data_reg;
    logic [23:0] len_reg;
    logic        zl_reg;
    logic [31:0] pos_reg;

    assign pop = head_valid && (!valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ch.ready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_reg <= head_token.event_res;
            addr_reg  <= {1'b0, head_token.offset} + {9'd0, head_token.index};
            data_reg  <= head_token.data_byte;
            len_reg   <= head_token.run_length;
            zl_reg    <= (head_token.event_res == ipsp_pkg::EV_RLE) &&
                         (head_token.run_length == 24'd0);
            pos_reg   <= head_token.hunk_position;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.event_res      = event_reg;
    assign out_ch.target_address = addr_reg;
    assign out_ch.data_byte      = data_reg;
    assign out_ch.run_length     = len_reg;
    assign out_ch.zero_length    = zl_reg;
    assign out_ch.hunk_position  = pos_reg;

endmodule

/* dv/tb.sv */
// testbench for the ips patch stream parser: random patch streams against a built-in parser model
`timescale 1ns / 1ps

module tb;

    localparam logic [39:0] MAGIC_WORD = "PATCH";
    localparam logic [23:0] EOF_WORD   = 24'h454F46;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASE_BEATS = 265;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_OFFSET,
        PH_LENGTH,
        PH_RLE_LENGTH,
        PH_RLE_FILL,
        PH_PAYLOAD,
        PH_AFTER_EOF,
        PH_TRUNC,
        PH_TAIL,
        PH_FINISHED,
        PH_FAILED
    } parse_phase_t;

    typedef struct packed {
        logic [3:0]  ev;
        logic [24:0] addr;
        logic [7:0]  data;
        logic [23:0] len;
        logic        zl;
        logic [31:0] pos;
    } patch_event_t;

    class patch_scoreboard;
        patch_event_t expected_events[$];
        int           errors;
        bit           trunc_en;
        parse_phase_t ph;
        logic [23:0]  shift;
        logic [2:0]   cnt;
        logic [23:0]  hunk_off;
        logic [15:0]  hunk_len;
        logic [15:0]  pay_idx;
        logic [31:0]  stream_pos;
        logic [31:0]  record_pos;

        function new();
            errors     = 0;
            trunc_en   = 1'b0;
            ph         = PH_MAGIC;
            shift      = '0;
            cnt        = '0;
            hunk_off   = '0;
            hunk_len   = '0;
            pay_idx    = '0;
            stream_pos = '0;
            record_pos = '0;
        endfunction

        function void set_trunc(bit v);
            trunc_en = v;
        endfunction

        function void enter(parse_phase_t p);
            ph    = p;
            shift = '0;
            cnt   = '0;
        endfunction

        function void queue_event(logic [3:0] ev, logic [24:0] addr, logic [7:0] data,
                                  logic [23:0] len, logic zl, logic [31:0] pos);
            patch_event_t e;
            e.ev   = ev;
            e.addr = addr;
            e.data = data;
            e.len  = len;
            e.zl   = zl;
            e.pos  = pos;
            expected_events.push_back(e);
        endfunction

        function bit shift_in(logic [7:0] b, int width);
            shift = {shift[15:0], b};
            cnt   = cnt + 3'd1;
            return int'(cnt) >= width;
        endfunction

        // advances the parser by one accepted input beat
        function void take_beat(logic cmd, logic [7:0] b);
            logic [31:0] pos;
            logic [24:0] addr;
            pos = stream_pos;
            if (ph == PH_FINISHED || ph == PH_FAILED)
                return;
            if (cmd)
            begin
                if (ph == PH_AFTER_EOF || ph == PH_TAIL || (ph == PH_TRUNC && cnt == 0))
                begin
                    enter(PH_FINISHED);
                    queue_event(ipsp_pkg::EV_DONE, '0, '0, '0, 1'b0, '0);
                end
                else
                begin
                    enter(PH_FAILED);
                    queue_event(ipsp_pkg::EV_EARLY_END, '0, '0, '0, 1'b0, '0);
                end
                return;
            end
            if (stream_pos != 32'hFFFF_FFFF)
                stream_pos = stream_pos + 32'd1;
            case (ph)
                PH_MAGIC:
                begin
                    if (cnt < 5 && b != MAGIC_WORD[39 - 8 * cnt -: 8])
                        shift = 24'd1;
                    cnt = cnt + 3'd1;
                    if (cnt < 5)
                        return;
                    if (shift != 0)
                    begin
                        enter(PH_FAILED);
                        queue_event(ipsp_pkg::EV_BAD_MAGIC, '0, '0, '0, 1'b0, '0);
                    end
                    else
                    begin
                        enter(PH_OFFSET);
                        queue_event(ipsp_pkg::EV_MAGIC_OK, '0, '0, '0, 1'b0, '0);
                    end
                end
                PH_OFFSET:
                begin
                    if (cnt == 0)
                        record_pos = pos;
                    if (!shift_in(b, 3))
                        return;
                    if (shift == EOF_WORD)
                    begin
                        enter(trunc_en ? PH_TRUNC : PH_AFTER_EOF);
                        queue_event(ipsp_pkg::EV_EOF, '0, '0, '0, 1'b0, record_pos);
                    end
                    else
                    begin
                        hunk_off = shift;
                        enter(PH_LENGTH);
                    end
                end
                PH_LENGTH:
                begin
                    if (!shift_in(b, 2))
                        return;
                    hunk_len = shift[15:0];
                    if (hunk_len != 0)
                    begin
                        pay_idx = '0;
                        enter(PH_PAYLOAD);
                        queue_event(ipsp_pkg::EV_REGULAR, {1'b0, hunk_off}, '0,
                                    {8'd0, hunk_len}, 1'b0, record_pos);
                    end
                    else
                        enter(PH_RLE_LENGTH);
                end
                PH_RLE_LENGTH:
                begin
                    if (!shift_in(b, 2))
                        return;
                    hunk_len = shift[15:0];
                    enter(PH_RLE_FILL);
                end
                PH_RLE_FILL:
                begin
                    enter(PH_OFFSET);
                    queue_event(ipsp_pkg::EV_RLE, {1'b0, hunk_off}, b, {8'd0, hunk_len},
                                hunk_len == 0, record_pos);
                end
                PH_PAYLOAD:
                begin
                    addr    = {1'b0, hunk_off} + {9'd0, pay_idx};
                    pay_idx = pay_idx + 16'd1;
                    if (pay_idx >= hunk_len)
                        enter(PH_OFFSET);
                    queue_event(ipsp_pkg::EV_WRITE, addr, b, {8'd0, hunk_len}, 1'b0, '0);
                end
                PH_TRUNC:
                begin
                    if (!shift_in(b, 3))
                        return;
                    queue_event(ipsp_pkg::EV_TRUNCATE, '0, '0, shift, 1'b0, '0);
                    enter(PH_TAIL);
                end
                PH_TAIL:
                begin
                    enter(PH_AFTER_EOF);
                    queue_event(ipsp_pkg::EV_TRAILING, '0, '0, '0, 1'b0, '0);
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_event(patch_event_t got);
            patch_event_t want;
            if (expected_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected event: expected none, actual ev=%0d addr=0x%0h",
                         $time, got.ev, got.addr);
                return;
            end
            want = expected_events.pop_front();
            cmp_field("event_res", 32'(want.ev), 32'(got.ev));
            cmp_field("target_address", 32'(want.addr), 32'(got.addr));
            cmp_field("data_byte", 32'(want.data), 32'(got.data));
            cmp_field("run_length", 32'(want.len), 32'(got.len));
            cmp_field("zero_length", 32'(want.zl), 32'(got.zl));
            cmp_field("hunk_position", want.pos, got.pos);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ipsp_in_if  in_ch ();
    ipsp_out_if out_ch ();

    ips_patch_stream_parser_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    patch_scoreboard sb;
    int              sender_idle_pct;
    int              sink_stall_pct;
    int              beats_sent;
    int              quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        patch_event_t got;
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_trunc(cfg_wdata);
            if (in_ch.valid && in_ch.ready)
                sb.take_beat(in_ch.command, in_ch.byte_value);
            if (out_ch.valid && out_ch.ready)
            begin
                got.ev   = out_ch.event_res;
                got.addr = out_ch.target_address;
                got.data = out_ch.data_byte;
                got.len  = out_ch.run_length;
                got.zl   = out_ch.zero_length;
                got.pos  = out_ch.hunk_position;
                sb.check_event(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.byte_value <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic send_field(input logic [23:0] v, input int n);
        for (int k = n - 1; k >= 0; k--)
            send_beat(1'b0, v[8 * k +: 8]);
    endtask

    task automatic send_regular(input logic [23:0] off, input logic [15:0] len);
        send_field(off, 3);
        send_field({8'd0, len}, 2);
        repeat (len)
            send_beat(1'b0, 8'($urandom));
    endtask

    task automatic send_rle(input logic [23:0] off, input logic [15:0] run, input logic [7:0] fill);
        send_field(off, 3);
        send_field(24'd0, 2);
        send_field({8'd0, run}, 2);
        send_beat(1'b0, fill);
    endtask

    // input idle until every expected event has been checked, plus extra clocks
    task automatic settle(input int extra);
        in_ch.valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic write_trunc(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_hunk();
        logic [23:0] off;
        int          pick;
        int          len;
        off = 24'($urandom);
        if ($urandom_range(9) == 0)
            off = 24'hFFFFFF - 24'($urandom_range(3));
        if (off == EOF_WORD)
            off = off ^ 24'd1;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                len = $urandom_range(8, 1);
            else if (pick < 97)
                len = $urandom_range(64, 9);
            else
                len = $urandom_range(300, 256);
            send_regular(off, 16'(len));
        end
        else
            send_rle(off, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom), 8'($urandom));
    endtask

    task automatic finish_stream(input int ending);
        int n;
        case (ending)
            0:
            begin
                send_field(EOF_WORD, 3);
                repeat ($urandom_range(4, 1))
                    send_beat(1'b0, 8'($urandom));
                send_beat(1'b1, 8'($urandom));
            end
            1:
            begin
                send_field(EOF_WORD, 3);
                send_field(24'($urandom), 3);
                repeat ($urandom_range(4, 1))
                    send_beat(1'b0, 8'($urandom));
                send_beat(1'b1, 8'($urandom));
            end
            2:
            begin
                send_field(EOF_WORD, 3);
                send_beat(1'b1, 8'($urandom));
            end
            3:
            begin
                n = $urandom_range(2);
                if (n == 1)
                    send_field(24'($urandom), $urandom_range(2, 1));
                else if (n == 2)
                begin
                    send_field(24'h000100, 3);
                    send_field(24'd5, 2);
                    repeat ($urandom_range(4))
                        send_beat(1'b0, 8'($urandom));
                end
                send_beat(1'b1, 8'($urandom));
            end
            default:
            begin
                send_field(EOF_WORD, 3);
                send_field(24'($urandom), $urandom_range(2, 1));
                send_beat(1'b1, 8'($urandom));
            end
        endcase
        // the parser is closed now; these beats must leave no trace
        repeat (6)
            send_beat(1'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int ending;
        int start;
        sb              = new();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        beats_sent      = 0;
        quiet_cycles    = 0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= 1'b0;
        in_ch.byte_value <= 8'd0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_trunc(1'b1);

        // directed opening: magic, address extremes, zero and full rle runs
        send_field(MAGIC_WORD[39:16], 3);
        send_field({8'd0, MAGIC_WORD[15:0]}, 2);
        send_regular(24'h000000, 16'd1);
        send_regular(24'hFFFFFF, 16'd3);
        send_rle(24'h000000, 16'd0, 8'h00);
        send_rle(24'hFFFFFE, 16'hFFFF, 8'hFF);
        send_regular(24'h454F47, 16'd2);

        for (int m = 0; m < 4; m++)
        begin
            settle(4);
            write_trunc(m[0]);
            case (m)
                0:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 46;
                    sink_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 46;
                end
                default:
                begin
                    sender_idle_pct = 35;
                    sink_stall_pct  = 35;
                end
            endcase
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
                random_hunk();
        end

        settle(4);
        ending = $urandom_range(4);
        write_trunc(ending != 0);
        finish_stream(ending);

        settle(20);
        if (sb.expected_events.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected events never arrived", $time, sb.expected_events.size());
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
